// ===== hw/rtl/cot_pkg.sv =====
// Shared constants, types and codes of the capability ownership table.
package cot_pkg;

  localparam int unsigned TableDepth  = 512;
  localparam int unsigned MaxQueryOut = 64;

  localparam int unsigned AddrW  = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW   = $clog2(TableDepth + 1);
  localparam int unsigned QryW   = $clog2(MaxQueryOut + 1);
  localparam int unsigned CountW = 10;
  localparam int unsigned MaxOutW = 7;

  typedef enum logic [1:0] {
    KindRegister = 2'd0,
    KindRevoke   = 2'd1,
    KindQuery    = 2'd2,
    KindVerify   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [31:0] cap_id;
    logic [31:0] pid;
    logic [31:0] mod_id;
    logic [7:0]  rights;
    logic        exit_revoke;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

// ===== hw/rtl/cot_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cot_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/capability_ownership_table.sv =====
// Top level of the capability ownership table: sequencer, record store and result register.
//
//   channel  | handshake               | words
//   ---------+-------------------------+-----------------------------------------------
//   command  | start & !busy           | kind_i, cap_id_i, pid_i, mod_id_i, rights_i,
//            |                         | exit_revoke_i, need_rights_i, max_out_i
//   result   | valid_o, one cycle each | status_o, count_o, granted_o, record_valid_o,
//            |                         | rec_*_o, last_o
//
// A register command's result word follows in the next cycle and busy stays low.
// Revoke and verify walk the store through the single read port, one record a
// cycle. Query walks it once to count the matches, up to the saturated limit, and,
// if there are any, again one record a cycle to emit one word per matching record.
// The store's one read port sets this pace. Reset clears the record count, the
// sequencer and the result strobe only; the store itself is not cleared.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module capability_ownership_table
  import cot_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind_i,
  input  logic [31:0]        cap_id_i,
  input  logic [31:0]        pid_i,
  input  logic [31:0]        mod_id_i,
  input  logic [7:0]         rights_i,
  input  logic               exit_revoke_i,
  input  logic [7:0]         need_rights_i,
  input  logic [MaxOutW-1:0] max_out_i,
  output logic               valid_o,
  output logic               status_o,
  output logic [CountW-1:0]  count_o,
  output logic               granted_o,
  output logic               record_valid_o,
  output logic [31:0]        rec_cap_id_o,
  output logic [31:0]        rec_pid_o,
  output logic [31:0]        rec_mod_id_o,
  output logic [7:0]         rec_rights_o,
  output logic               rec_exit_revoke_o,
  output logic               last_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StEmit
  } state_e;

  state_e state_q, state_d;

  // latched command word
  kind_e       kind_q, kind_d;
  logic [31:0] cap_q, cap_d;
  logic [31:0] pid_q, pid_d;
  logic [31:0] mod_q, mod_d;
  logic [7:0]  req_q, req_d;
  logic [QryW-1:0] maxo_q, maxo_d;

  // table and walk state
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic             rv_q, rv_d;
  logic [AddrW-1:0] rv_idx_q, rv_idx_d;
  logic [QryW-1:0]  found_q, found_d;
  logic [QryW-1:0]  emit_q, emit_d;
  logic [CntW-1:0]  acc_q, acc_d;
  logic             hit_q, hit_d;
  logic             grant_q, grant_d;

  // result register
  logic         res_valid_q, res_valid_d;
  logic         res_status_q, res_status_d;
  logic [CountW-1:0] res_count_q, res_count_d;
  logic         res_granted_q, res_granted_d;
  logic         res_rvalid_q, res_rvalid_d;
  entry_t       res_rec_q, res_rec_d;
  logic         res_last_q, res_last_d;

  // store port
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  entry_t           rd_entry;
  logic [EntryW-1:0] ram_rdata;

  logic issue;
  logic full;
  logic q_match;
  logic r_match;
  logic v_match;
  logic [MaxOutW-1:0] max_sat;

  assign rd_entry = entry_t'(ram_rdata);
  assign issue    = (rd_idx_q < cnt_q);
  assign full     = (cnt_q >= CntW'(TableDepth));
  assign q_match  = (rd_entry.mod_id == mod_q) && (rd_entry.rights != 8'd0);
  assign r_match  = (rd_entry.pid == pid_q) && rd_entry.exit_revoke;
  assign v_match  = (rd_entry.cap_id == cap_q) && (rd_entry.pid == pid_q);
  assign max_sat  = (max_out_i > MaxOutW'(MaxQueryOut)) ? MaxOutW'(MaxQueryOut) : max_out_i;

  cot_ram #(
    .Width (EntryW),
    .Depth (TableDepth),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    cap_d    = cap_q;
    pid_d    = pid_q;
    mod_d    = mod_q;
    req_d    = req_q;
    maxo_d   = maxo_q;
    cnt_d    = cnt_q;
    rd_idx_d = rd_idx_q;
    rv_d     = 1'b0;
    rv_idx_d = rv_idx_q;
    found_d  = found_q;
    emit_d   = emit_q;
    acc_d    = acc_q;
    hit_d    = hit_q;
    grant_d  = grant_q;

    res_valid_d   = 1'b0;
    res_status_d  = res_status_q;
    res_count_d   = res_count_q;
    res_granted_d = res_granted_q;
    res_rvalid_d  = res_rvalid_q;
    res_rec_d     = res_rec_q;
    res_last_d    = res_last_q;

    ram_we    = 1'b0;
    ram_waddr = cnt_q[AddrW-1:0];
    ram_wdata = '{cap_id: cap_id_i, pid: pid_i, mod_id: mod_id_i,
                  rights: rights_i, exit_revoke: exit_revoke_i};
    ram_re    = 1'b0;
    ram_raddr = rd_idx_q[AddrW-1:0];

    unique case (state_q)
      StIdle: begin
        if (start) begin
          kind_d   = kind_e'(kind_i);
          cap_d    = cap_id_i;
          pid_d    = pid_i;
          mod_d    = mod_id_i;
          req_d    = need_rights_i;
          maxo_d   = QryW'(max_sat);
          rd_idx_d = '0;
          found_d  = '0;
          emit_d   = '0;
          acc_d    = '0;
          hit_d    = 1'b0;
          grant_d  = 1'b0;
          if (kind_e'(kind_i) == KindRegister) begin
            // append in place unless full, answer next cycle
            res_valid_d   = 1'b1;
            res_status_d  = full;
            res_count_d   = '0;
            res_granted_d = 1'b0;
            res_rvalid_d  = 1'b0;
            res_rec_d     = '0;
            res_last_d    = 1'b1;
            if (!full) begin
              ram_we = 1'b1;
              cnt_d  = cnt_q + CntW'(1);
            end
          end else begin
            state_d = StScan;
          end
        end
      end

      StScan: begin
        if (rv_q) begin
          unique case (kind_q)
            KindRevoke: begin
              if (r_match) begin
                ram_we           = 1'b1;
                ram_waddr        = rv_idx_q;
                ram_wdata        = rd_entry;
                ram_wdata.rights = 8'd0;
                ram_wdata.pid    = 32'd0;
                acc_d            = acc_q + CntW'(1);
              end
            end
            KindQuery: begin
              if (q_match && (found_q < maxo_q)) begin
                found_d = found_q + QryW'(1);
              end
            end
            KindVerify: begin
              if (v_match && !hit_q) begin
                hit_d   = 1'b1;
                grant_d = ((rd_entry.rights & req_q) == req_q);
              end
            end
            default: begin
            end
          endcase
        end

        if (issue) begin
          ram_re   = 1'b1;
          rv_d     = 1'b1;
          rv_idx_d = rd_idx_q[AddrW-1:0];
          rd_idx_d = rd_idx_q + CntW'(1);
        end else if (!rv_q) begin
          // walk done: answer, or start the emit walk
          res_status_d  = 1'b0;
          res_count_d   = '0;
          res_granted_d = 1'b0;
          res_rvalid_d  = 1'b0;
          res_rec_d     = '0;
          res_last_d    = 1'b1;
          state_d       = StIdle;
          unique case (kind_q)
            KindRevoke: begin
              res_valid_d = 1'b1;
              res_count_d = CountW'(acc_q);
            end
            KindVerify: begin
              res_valid_d   = 1'b1;
              res_granted_d = grant_q;
            end
            KindQuery: begin
              if (found_q == '0) begin
                res_valid_d = 1'b1;
              end else begin
                state_d  = StEmit;
                rd_idx_d = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      StEmit: begin
        if (rv_q && q_match) begin
          res_valid_d   = 1'b1;
          res_status_d  = 1'b0;
          res_count_d   = CountW'(found_q);
          res_granted_d = 1'b0;
          res_rvalid_d  = 1'b1;
          res_rec_d     = rd_entry;
          res_last_d    = ((emit_q + QryW'(1)) == found_q);
          emit_d        = emit_q + QryW'(1);
          if ((emit_q + QryW'(1)) == found_q) begin
            state_d = StIdle;
          end
        end
        if (issue) begin
          ram_re   = 1'b1;
          rv_d     = 1'b1;
          rv_idx_d = rd_idx_q[AddrW-1:0];
          rd_idx_d = rd_idx_q + CntW'(1);
        end else if (!rv_q) begin
          // drop out if the walk ends without the last word
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      rv_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rv_q        <= rv_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload and walk registers: no reset
  always_ff @(posedge clk_i) begin
    kind_q        <= kind_d;
    cap_q         <= cap_d;
    pid_q         <= pid_d;
    mod_q         <= mod_d;
    req_q         <= req_d;
    maxo_q        <= maxo_d;
    rd_idx_q      <= rd_idx_d;
    rv_idx_q      <= rv_idx_d;
    found_q       <= found_d;
    emit_q        <= emit_d;
    acc_q         <= acc_d;
    hit_q         <= hit_d;
    grant_q       <= grant_d;
    res_status_q  <= res_status_d;
    res_count_q   <= res_count_d;
    res_granted_q <= res_granted_d;
    res_rvalid_q  <= res_rvalid_d;
    res_rec_q     <= res_rec_d;
    res_last_q    <= res_last_d;
  end

  assign busy              = (state_q != StIdle);
  assign valid_o           = res_valid_q;
  assign status_o          = res_status_q;
  assign count_o           = res_count_q;
  assign granted_o         = res_granted_q;
  assign record_valid_o    = res_rvalid_q;
  assign rec_cap_id_o      = res_rec_q.cap_id;
  assign rec_pid_o         = res_rec_q.pid;
  assign rec_mod_id_o      = res_rec_q.mod_id;
  assign rec_rights_o      = res_rec_q.rights;
  assign rec_exit_revoke_o = res_rec_q.exit_revoke;
  assign last_o            = res_last_q;

endmodule

// ===== bench/capability_ownership_table_tb.sv =====
// Self-checking testbench for the capability ownership table: directed and random commands.
`timescale 1ns / 1ps

module capability_ownership_table_tb
  import cot_pkg::*;
();

  // Give the run generous headroom: even a queue of full-table scans ends far below this.
  localparam int unsigned CycleLimit = 1_000_000;
  // Allow one worst-case query pass plus slack after the last expected word.
  localparam int unsigned SettleCycles = 2 * TableDepth + 8;
  localparam int unsigned PoolSize = 8;

  // One command word as the sender sees it.
  typedef struct {
    kind_e                kind;
    logic [31:0]          cap_id;
    logic [31:0]          pid;
    logic [31:0]          mod_id;
    logic [7:0]           rights;
    logic                 exit_revoke;
    logic [7:0]           need_rights;
    logic [MaxOutW-1:0]   max_out;
  } cmd_t;

  // One result word as the block should show it.
  typedef struct packed {
    logic              status;
    logic [CountW-1:0] count;
    logic              granted;
    logic              record_valid;
    entry_t            rec;
    logic              last;
  } word_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         kind_i;
  logic [31:0]        cap_id_i;
  logic [31:0]        pid_i;
  logic [31:0]        mod_id_i;
  logic [7:0]         rights_i;
  logic               exit_revoke_i;
  logic [7:0]         need_rights_i;
  logic [MaxOutW-1:0] max_out_i;
  logic               valid_o;
  logic               status_o;
  logic [CountW-1:0]  count_o;
  logic               granted_o;
  logic               record_valid_o;
  logic [31:0]        rec_cap_id_o;
  logic [31:0]        rec_pid_o;
  logic [31:0]        rec_mod_id_o;
  logic [7:0]         rec_rights_o;
  logic               rec_exit_revoke_o;
  logic               last_o;

  // Shadow copy of the record store, kept in step with accepted commands.
  entry_t      shadow_rec [TableDepth];
  int unsigned shadow_count;
  word_t       pending_words [$];

  logic [31:0] pid_pool [PoolSize];
  logic [31:0] mod_pool [PoolSize];
  logic [31:0] cap_pool [PoolSize];

  int unsigned idle_pct;
  int unsigned error_count;
  int unsigned cycle_count;

  capability_ownership_table i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .cap_id_i         (cap_id_i),
    .pid_i            (pid_i),
    .mod_id_i         (mod_id_i),
    .rights_i         (rights_i),
    .exit_revoke_i    (exit_revoke_i),
    .need_rights_i    (need_rights_i),
    .max_out_i        (max_out_i),
    .valid_o          (valid_o),
    .status_o         (status_o),
    .count_o          (count_o),
    .granted_o        (granted_o),
    .record_valid_o   (record_valid_o),
    .rec_cap_id_o     (rec_cap_id_o),
    .rec_pid_o        (rec_pid_o),
    .rec_mod_id_o     (rec_mod_id_o),
    .rec_rights_o     (rec_rights_o),
    .rec_exit_revoke_o(rec_exit_revoke_o),
    .last_o           (last_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Work out the result words of one accepted command and advance the shadow store.
  function automatic void apply_to_shadow_store(input cmd_t c);
    word_t       w;
    word_t       hits [$];
    int unsigned limit;
    int unsigned revoked;
    w = '0;
    w.last = 1'b1;
    case (c.kind)
      KindRegister: begin
        if (shadow_count >= TableDepth) begin
          w.status = 1'b1;
        end else begin
          shadow_rec[shadow_count] = '{cap_id: c.cap_id, pid: c.pid, mod_id: c.mod_id,
                                       rights: c.rights, exit_revoke: c.exit_revoke};
          shadow_count++;
        end
        pending_words.push_back(w);
      end
      KindRevoke: begin
        revoked = 0;
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (shadow_rec[i].pid == c.pid && shadow_rec[i].exit_revoke) begin
            shadow_rec[i].rights = '0;
            shadow_rec[i].pid    = '0;
            revoked++;
          end
        end
        w.count = revoked[CountW-1:0];
        pending_words.push_back(w);
      end
      KindQuery: begin
        // Saturate the limit, then collect matches in store order.
        limit = (c.max_out > MaxQueryOut) ? MaxQueryOut : c.max_out;
        for (int unsigned i = 0; i < shadow_count && hits.size() < limit; i++) begin
          if (shadow_rec[i].mod_id == c.mod_id && shadow_rec[i].rights != '0) begin
            w = '0;
            w.record_valid = 1'b1;
            w.rec = shadow_rec[i];
            hits.push_back(w);
          end
        end
        if (hits.size() == 0) begin
          w = '0;
          w.last = 1'b1;
          pending_words.push_back(w);
        end else begin
          foreach (hits[k]) begin
            hits[k].count = CountW'(hits.size());
            hits[k].last  = (k == hits.size() - 1);
            pending_words.push_back(hits[k]);
          end
        end
      end
      default: begin
        // The first id/process match decides, revoked or not.
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (shadow_rec[i].cap_id == c.cap_id && shadow_rec[i].pid == c.pid) begin
            w.granted = ((shadow_rec[i].rights & c.need_rights) == c.need_rights);
            break;
          end
        end
        pending_words.push_back(w);
      end
    endcase
  endfunction

  // Fill every field with noise; the constructors below override what the kind uses.
  function automatic cmd_t noise_cmd(input kind_e kind);
    cmd_t c;
    c.kind        = kind;
    c.cap_id      = $urandom;
    c.pid         = $urandom;
    c.mod_id      = $urandom;
    c.rights      = 8'($urandom_range(255));
    c.exit_revoke = 1'($urandom_range(1));
    c.need_rights = 8'($urandom_range(255));
    c.max_out     = 7'($urandom_range(127));
    return c;
  endfunction

  function automatic cmd_t mk_register(input logic [31:0] cap, input logic [31:0] pid,
                                       input logic [31:0] mod, input logic [7:0] rights,
                                       input logic auto_rev);
    cmd_t c;
    c = noise_cmd(KindRegister);
    c.cap_id      = cap;
    c.pid         = pid;
    c.mod_id      = mod;
    c.rights      = rights;
    c.exit_revoke = auto_rev;
    return c;
  endfunction

  function automatic cmd_t mk_revoke(input logic [31:0] pid);
    cmd_t c;
    c = noise_cmd(KindRevoke);
    c.pid = pid;
    return c;
  endfunction

  function automatic cmd_t mk_query(input logic [31:0] mod, input logic [MaxOutW-1:0] max_out);
    cmd_t c;
    c = noise_cmd(KindQuery);
    c.mod_id  = mod;
    c.max_out = max_out;
    return c;
  endfunction

  function automatic cmd_t mk_verify(input logic [31:0] cap, input logic [31:0] pid,
                                     input logic [7:0] req);
    cmd_t c;
    c = noise_cmd(KindVerify);
    c.cap_id      = cap;
    c.pid         = pid;
    c.need_rights = req;
    return c;
  endfunction

  function automatic logic [31:0] pick(input logic [31:0] pool [PoolSize], input int unsigned pct);
    return ($urandom_range(99) < pct) ? pool[$urandom_range(PoolSize - 1)] : $urandom;
  endfunction

  // Build one random command; most of them hit records already held.
  function automatic cmd_t random_cmd();
    cmd_t        c;
    int unsigned sel;
    int unsigned idx;
    sel = $urandom_range(99);
    if (sel < 35) begin
      c = mk_register(pick(cap_pool, 30), pick(pid_pool, 80), pick(mod_pool, 80),
                      ($urandom_range(99) < 15) ? 8'h00 : 8'($urandom_range(255)),
                      1'($urandom_range(1)));
    end else if (sel < 50) begin
      c = mk_revoke(pick(pid_pool, 85));
    end else if (sel < 75) begin
      c = mk_query(pick(mod_pool, 85), ($urandom_range(99) < 60) ? 7'($urandom_range(1, 8))
                                                               : 7'($urandom_range(127)));
    end else if (shadow_count > 0 && $urandom_range(99) < 75) begin
      idx = $urandom_range(shadow_count - 1);
      c = mk_verify(shadow_rec[idx].cap_id, shadow_rec[idx].pid,
                    ($urandom_range(1) == 1) ? (shadow_rec[idx].rights & 8'($urandom))
                                             : 8'($urandom_range(255)));
    end else begin
      c = mk_verify(pick(cap_pool, 50), pick(pid_pool, 70), 8'($urandom_range(255)));
    end
    return c;
  endfunction

  // Drive one command word and hold it until the block takes it.
  task automatic send_word(input cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    kind_i        <= c.kind;
    cap_id_i      <= c.cap_id;
    pid_i         <= c.pid;
    mod_id_i      <= c.mod_id;
    rights_i      <= c.rights;
    exit_revoke_i <= c.exit_revoke;
    need_rights_i <= c.need_rights;
    max_out_i     <= c.max_out;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    apply_to_shadow_store(c);
  endtask

  // Empty store: every lookup misses, and a revoke counts nothing.
  task automatic test_empty_store();
    send_word(mk_query(32'h0, 7'd64));
    send_word(mk_verify(32'h0, 32'h0, 8'h00));
    send_word(mk_revoke(32'h0));
  endtask

  // Store records at the field extremes, plus a duplicate id/process pair.
  task automatic test_register_extremes();
    send_word(mk_register(32'h0, 32'h0, 32'h0, 8'h00, 1'b0));
    send_word(mk_register(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1));
    send_word(mk_register(32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0, 8'h0F, 1'b1));
    send_word(mk_register(32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0, 8'hF0, 1'b0));
    send_word(mk_register(32'h1, 32'hFFFF_FFFF, 32'h0, 8'h80, 1'b1));
  endtask

  // Zero required rights pass on a matching record; the first matching record decides.
  task automatic test_verify_rules();
    send_word(mk_verify(32'h0, 32'h0, 8'h00));
    send_word(mk_verify(32'h0, 32'h0, 8'h01));
    send_word(mk_verify(32'hA5A5_A5A5, 32'h5A5A_5A5A, 8'h0F));
    send_word(mk_verify(32'hA5A5_A5A5, 32'h5A5A_5A5A, 8'hF0));
    send_word(mk_verify(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
  endtask

  // Limit of zero, a cut-off list, a saturated limit, and rightless records skipped.
  task automatic test_query_limits();
    send_word(mk_query(32'h0, 7'd0));
    send_word(mk_query(32'h0, 7'd1));
    send_word(mk_query(32'h0, 7'd127));
    send_word(mk_query(32'hFFFF_FFFF, 7'd64));
  endtask

  // Revoke strips auto-revoke records; revoked slots still match process 0.
  task automatic test_revoke();
    send_word(mk_revoke(32'hFFFF_FFFF));
    send_word(mk_query(32'h0, 7'd64));
    send_word(mk_verify(32'hFFFF_FFFF, 32'h0, 8'h00));
    send_word(mk_verify(32'hFFFF_FFFF, 32'h0, 8'h01));
    send_word(mk_revoke(32'hFFFF_FFFF));
  endtask

  task automatic test_random_traffic(input int unsigned n_words, input int unsigned pct);
    idle_pct = pct;
    repeat (n_words) send_word(random_cmd());
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Compare every strobed result word with the oldest expectation.
  always @(posedge clk_i) begin : check_words
    word_t want;
    if (rst_ni && valid_o === 1'b1) begin
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected");
        error_count++;
      end else begin
        want = pending_words.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("count", 32'(want.count), 32'(count_o));
        check_field("granted", 32'(want.granted), 32'(granted_o));
        check_field("record_valid", 32'(want.record_valid), 32'(record_valid_o));
        check_field("rec_cap_id", want.rec.cap_id, rec_cap_id_o);
        check_field("rec_pid", want.rec.pid, rec_pid_o);
        check_field("rec_mod_id", want.rec.mod_id, rec_mod_id_o);
        check_field("rec_rights", 32'(want.rec.rights), 32'(rec_rights_o));
        check_field("rec_exit_revoke", 32'(want.rec.exit_revoke), 32'(rec_exit_revoke_o));
        check_field("last", 32'(want.last), 32'(last_o));
      end
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("capability_ownership_table_tb: errors");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    kind_i        = '0;
    cap_id_i      = '0;
    pid_i         = '0;
    mod_id_i      = '0;
    rights_i      = '0;
    exit_revoke_i = 1'b0;
    need_rights_i = '0;
    max_out_i     = '0;
    idle_pct      = 0;
    error_count   = 0;
    cycle_count   = 0;
    shadow_count  = 0;

    // Seed the pools with the extremes and a spread of random values;
    // process 0 also catches revoked records.
    pid_pool[0] = 32'h0;
    mod_pool[0] = 32'h0;
    cap_pool[0] = 32'h0;
    pid_pool[1] = 32'hFFFF_FFFF;
    mod_pool[1] = 32'hFFFF_FFFF;
    cap_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < PoolSize; i++) begin
      pid_pool[i] = $urandom;
      mod_pool[i] = $urandom;
      cap_pool[i] = $urandom;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_store();
    test_register_extremes();
    test_verify_rules();
    test_query_limits();
    test_revoke();
    // Run random traffic back to back, then with a sparse and a lightly gapped sender.
    test_random_traffic(70, 0);
    test_random_traffic(70, 84);
    test_random_traffic(60, 14);
    start <= 1'b0;

    // Hold until every expected word is in, then watch for strays.
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("capability_ownership_table_tb: clean");
    end else begin
      $display("capability_ownership_table_tb: errors");
    end
    $finish;
  end

endmodule
